/* rtl/core/ddpt_pkg.sv */
`timescale 1ns / 1ps

package ddpt_pkg;

  // geometry
  localparam int CHANNELS    = 2;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_BITS  = 16;
  localparam int TAB_DEPTH   = 1024;
  localparam int TAB_BITS    = $clog2(TAB_DEPTH);
  localparam int QTR_DEPTH   = TAB_DEPTH / 4;
  localparam int QB          = TAB_BITS - 2;

  // fixed point
  localparam int FRAC       = SAMPLE_BITS - 5;
  localparam int TAB_FRAC   = 14;
  localparam int TAB_W      = TAB_FRAC + 2;
  localparam int QS_W       = TAB_FRAC + 1;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_SHIFT = GAIN_BITS + 2 * FRAC - PHASE_BITS;
  localparam int ERR_W      = SAMPLE_BITS + 1;
  localparam int G_W        = 2 * SAMPLE_BITS + 2;
  localparam int G_LO_W     = G_W / 2;
  localparam int G_HI_W     = G_W - G_LO_W;
  localparam int MUL_W      = ((ERR_W > GAIN_BITS + 1) ? ERR_W : GAIN_BITS + 1) + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = G_W + GAIN_BITS + 2;
  localparam int CFG_IDX_W  = 2;

  localparam int     T_FRAC = 30;
  localparam longint ONE30  = longint'(1) << T_FRAC;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
    logic                          channel;
    logic                          restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] rotated_real;
    logic signed [SAMPLE_BITS-1:0] rotated_imag;
    logic [PHASE_BITS-1:0]         updated_phase;
    logic                          channel_out;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE     = 2'd0,
    REG_CONST_MODE    = 2'd1,
    REG_INIT_PHASE_A  = 2'd2,
    REG_INIT_PHASE_B  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ROT_RC,
    ST_ROT_IS,
    ST_ROT_IC,
    ST_ROT_RS,
    ST_YI,
    ST_ERR,
    ST_G_IE,
    ST_G_RE,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_UPDATE
  } seq_state_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADD_HI
  } acc_op_t;

  typedef logic [QS_W-1:0] qs_tab_t [QTR_DEPTH];

  // shift right by sh, truncating toward zero
  function automatic longint trunc_shift(longint v, int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  // sin(pi/2 * t), t in Q30 over [0, 1], odd polynomial, result Q1.14
  function automatic longint quarter_sine(longint t);
    longint t2;
    longint p;
    longint s;
    longint r;
    t2 = trunc_shift(t * t, T_FRAC);
    p  = -3864;
    p  = 172272 + trunc_shift(p * t2, T_FRAC);
    p  = -5026995 + trunc_shift(p * t2, T_FRAC);
    p  = 85569306 + trunc_shift(p * t2, T_FRAC);
    p  = -693598668 + trunc_shift(p * t2, T_FRAC);
    p  = 1686629713 + trunc_shift(p * t2, T_FRAC);
    s  = trunc_shift(p * t, T_FRAC);
    r  = trunc_shift(s + (longint'(1) << 15), 16);
    if (r < 0) r = 0;
    if (r > (longint'(1) << TAB_FRAC)) r = longint'(1) << TAB_FRAC;
    return r;
  endfunction

  function automatic qs_tab_t build_qs();
    qs_tab_t tb;
    for (int m = 0; m < QTR_DEPTH; m++) begin
      tb[m] = QS_W'(quarter_sine(longint'(m) <<< (T_FRAC - QB)));
    end
    return tb;
  endfunction

  localparam qs_tab_t          QS_TAB  = build_qs();
  localparam logic [QS_W-1:0]  QS_FULL = QS_W'(quarter_sine(ONE30));

  // sine of quadrant q, position m within the quarter
  function automatic logic signed [TAB_W-1:0] quad_sine(logic [1:0] q, logic [QB-1:0] m);
    logic [QB-1:0]           mm;
    logic [QS_W-1:0]         mag;
    logic signed [TAB_W-1:0] sv;
    mm = ~m + QB'(1);
    if (q[0]) begin
      mag = (m == '0) ? QS_FULL : QS_TAB[mm];
    end else begin
      mag = QS_TAB[m];
    end
    sv = $signed({1'b0, mag});
    return q[1] ? -sv : sv;
  endfunction

endpackage

/* rtl/core/ddpt_trig_rom.sv */
`timescale 1ns / 1ps

module ddpt_trig_rom (
  input  logic                                clk,
  input  logic [ddpt_pkg::TAB_BITS-1:0]       idx,
  output logic signed [ddpt_pkg::TAB_W-1:0]   sin_q,
  output logic signed [ddpt_pkg::TAB_W-1:0]   cos_q
);
  import ddpt_pkg::*;

  logic [1:0]    quad;
  logic [1:0]    quad_c;
  logic [QB-1:0] pos;

  assign quad   = idx[TAB_BITS-1 -: 2];
  assign quad_c = quad + 2'd1;
  assign pos    = idx[QB-1:0];

  always_ff @(posedge clk) begin
    sin_q <= quad_sine(quad, pos);
    cos_q <= quad_sine(quad_c, pos);
  end

endmodule

/* rtl/core/decision_directed_phase_tracker.sv */
`timescale 1ns / 1ps

// decision-directed carrier phase tracker, one phase register per channel.
// each item is de-rotated by its channel's phase (quarter-wave sine table,
// Q1.14), both axes are sliced to the qpsk (+-1) or 16-qam (+-1, +-3) grid,
// and the phase is lowered by step_size * (imag*err_re - real*err_im),
// wrapping in binary turns. restart reloads the channel phase from its
// initial register before the item is used. one result comes out per item.
// items are taken only in the idle state, which the block reaches again
// after its update step; the work is paced by the single shared 18x18
// multiplier that forms the four rotation products, the two error products
// and the gain product in two halves. the next item is accepted in idle.
// the result sits in an output register, so a waiting consumer only stalls
// the block at its final update step. configuration registers are written
// through cfg_* at any time (always ready) and should only change while no
// item is in flight.
module decision_directed_phase_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ddpt_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ddpt_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ddpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ddpt_pkg::GAIN_BITS-1:0]       cfg_data
);
  import ddpt_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(longint'(1) << (SAMPLE_BITS - 1));
  localparam logic signed [ACC_W-1:0] ROT_HALF  = ACC_W'(longint'(1) << (TAB_FRAC - 1));
  localparam logic signed [ACC_W-1:0] GAIN_HALF = ACC_W'(longint'(1) << (GAIN_SHIFT - 1));
  localparam logic signed [SAMPLE_BITS-1:0] LVL1 = SAMPLE_BITS'(1 << FRAC);
  localparam logic signed [SAMPLE_BITS-1:0] LVL2 = SAMPLE_BITS'(2 << FRAC);
  localparam logic signed [SAMPLE_BITS-1:0] LVL3 = SAMPLE_BITS'(3 << FRAC);

  // configuration
  logic [GAIN_BITS-1:0]  step_r;
  logic                  mode_r;
  logic [PHASE_BITS-1:0] init_a_r;
  logic [PHASE_BITS-1:0] init_b_r;

  // per-channel phase
  logic [PHASE_BITS-1:0] chan_phase_r [CHANNELS];

  // sequencer and working registers
  seq_state_t                    state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] xr_r, xi_r;
  logic [CH_W-1:0]               ch_r;
  logic [PHASE_BITS-1:0]         work_phase_r;
  logic signed [SAMPLE_BITS-1:0] yr_r, yi_r;
  logic signed [ERR_W-1:0]       er_r, ei_r;
  logic signed [G_HI_W-1:0]      ghi_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          out_valid_r;
  out_item_t                     out_r;

  // shared multiplier
  acc_op_t                       acc_op;
  logic signed [MUL_W-1:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       prod_ext;

  logic signed [TAB_W-1:0]       sin_v, cos_v;
  logic [CH_W-1:0]               in_ch;
  logic                          accept;
  logic                          upd_go;
  logic signed [ACC_W-1:0]       rot_shift;
  logic signed [SAMPLE_BITS-1:0] rot_sat;
  logic signed [SAMPLE_BITS-1:0] lvl_r, lvl_i;
  logic signed [ACC_W-1:0]       gain_rnd;
  logic [PHASE_BITS-1:0]         delta;
  logic [PHASE_BITS-1:0]         phase_new;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_ch     = CH_W'(in_data.channel);
  assign upd_go    = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);

  ddpt_trig_rom u_trig (
    .clk   (clk),
    .idx   (work_phase_r[PHASE_BITS-1 -: TAB_BITS]),
    .sin_q (sin_v),
    .cos_q (cos_v)
  );

  // round half up from Q1.14 products, saturate to the sample width
  always_comb begin
    rot_shift = (acc_r + ROT_HALF) >>> TAB_FRAC;
    if (rot_shift > SAT_MAX) begin
      rot_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (rot_shift < SAT_MIN) begin
      rot_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      rot_sat = rot_shift[SAMPLE_BITS-1:0];
    end
  end

  // slicer, zero goes to +1, +-2 goes outward
  function automatic logic signed [SAMPLE_BITS-1:0] slice_lvl(
    logic signed [SAMPLE_BITS-1:0] y, logic qam);
    logic signed [SAMPLE_BITS-1:0] lv;
    if (!qam) begin
      lv = (y >= 0) ? LVL1 : -LVL1;
    end else if (y >= 0) begin
      lv = (y >= LVL2) ? LVL3 : LVL1;
    end else begin
      lv = (y <= -LVL2) ? -LVL3 : -LVL1;
    end
    return lv;
  endfunction

  assign lvl_r = slice_lvl(yr_r, mode_r);
  assign lvl_i = slice_lvl(yi_r, mode_r);

  // phase step, round half up after the gain scaling
  assign gain_rnd  = acc_r + GAIN_HALF;
  assign delta     = gain_rnd[GAIN_SHIFT +: PHASE_BITS];
  assign phase_new = work_phase_r - delta;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP:  state_nxt = ST_ROT_RC;
      ST_ROT_RC:  state_nxt = ST_ROT_IS;
      ST_ROT_IS:  state_nxt = ST_ROT_IC;
      ST_ROT_IC:  state_nxt = ST_ROT_RS;
      ST_ROT_RS:  state_nxt = ST_YI;
      ST_YI:      state_nxt = ST_ERR;
      ST_ERR:     state_nxt = ST_G_IE;
      ST_G_IE:    state_nxt = ST_G_RE;
      ST_G_RE:    state_nxt = ST_GAIN_LO;
      ST_GAIN_LO: state_nxt = ST_GAIN_HI;
      ST_GAIN_HI: state_nxt = ST_UPDATE;
      ST_UPDATE:  if (upd_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operands and accumulate control
  always_comb begin
    acc_op = ACC_HOLD;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_ROT_RC: begin
        acc_op = ACC_LOAD;
        mul_a  = MUL_W'(xr_r);
        mul_b  = MUL_W'(cos_v);
      end
      ST_ROT_IS: begin
        acc_op = ACC_ADD;
        mul_a  = MUL_W'(xi_r);
        mul_b  = MUL_W'(sin_v);
      end
      ST_ROT_IC: begin
        acc_op = ACC_LOAD;
        mul_a  = MUL_W'(xi_r);
        mul_b  = MUL_W'(cos_v);
      end
      ST_ROT_RS: begin
        acc_op = ACC_SUB;
        mul_a  = MUL_W'(xr_r);
        mul_b  = MUL_W'(sin_v);
      end
      ST_G_IE: begin
        acc_op = ACC_LOAD;
        mul_a  = MUL_W'(yi_r);
        mul_b  = MUL_W'(er_r);
      end
      ST_G_RE: begin
        acc_op = ACC_SUB;
        mul_a  = MUL_W'(yr_r);
        mul_b  = MUL_W'(ei_r);
      end
      ST_GAIN_LO: begin
        acc_op = ACC_LOAD;
        mul_a  = $signed(MUL_W'(step_r));
        mul_b  = $signed(MUL_W'(acc_r[G_LO_W-1:0]));
      end
      ST_GAIN_HI: begin
        acc_op = ACC_ADD_HI;
        mul_a  = $signed(MUL_W'(step_r));
        mul_b  = MUL_W'(ghi_r);
      end
      default: begin
        acc_op = ACC_HOLD;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    case (acc_op)
      ACC_LOAD:   acc_nxt = prod_ext;
      ACC_ADD:    acc_nxt = acc_r + prod_ext;
      ACC_SUB:    acc_nxt = acc_r - prod_ext;
      ACC_ADD_HI: acc_nxt = acc_r + (prod_ext <<< G_LO_W);
      default:    acc_nxt = acc_r;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= GAIN_BITS'(655);
      mode_r      <= 1'b0;
      init_a_r    <= '0;
      init_b_r    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_phase_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        out_valid_r       <= 1'b1;
        chan_phase_r[ch_r] <= phase_new;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP_SIZE:    step_r   <= cfg_data;
          REG_CONST_MODE:   mode_r   <= cfg_data[0];
          REG_INIT_PHASE_A: init_a_r <= cfg_data[PHASE_BITS-1:0];
          REG_INIT_PHASE_B: init_b_r <= cfg_data[PHASE_BITS-1:0];
          default:          step_r   <= step_r;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (accept) begin
      xr_r <= in_data.sample_real;
      xi_r <= in_data.sample_imag;
      ch_r <= in_ch;
      if (in_data.restart) begin
        work_phase_r <= (in_ch == '0) ? init_a_r : init_b_r;
      end else begin
        work_phase_r <= chan_phase_r[in_ch];
      end
    end
    if (state_r == ST_ROT_IC) yr_r <= rot_sat;
    if (state_r == ST_YI)     yi_r <= rot_sat;
    if (state_r == ST_ERR) begin
      er_r <= ERR_W'(yr_r) - ERR_W'(lvl_r);
      ei_r <= ERR_W'(yi_r) - ERR_W'(lvl_i);
    end
    if (state_r == ST_GAIN_LO) ghi_r <= $signed(acc_r[G_W-1:G_LO_W]);
    if (upd_go) begin
      out_r.rotated_real  <= yr_r;
      out_r.rotated_imag  <= yi_r;
      out_r.updated_phase <= phase_new;
      out_r.channel_out   <= ch_r[0];
    end
  end

  // busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("block still ready after taking an item");

  // a new result only appears from the update step
  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_UPDATE))
    else $error("result raised outside the update step");

  // stored channel phase matches the reported phase
  a_phase_written: assert property (@(posedge clk) disable iff (!rst_n)
    $past(upd_go) |-> (chan_phase_r[ch_r] == out_data.updated_phase))
    else $error("channel phase differs from reported phase");

  // restart on channel zero starts from the initial phase
  a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.restart && (in_ch == '0) |=> work_phase_r == $past(init_a_r))
    else $error("restart did not load the initial phase");

endmodule

/* tb/ddpt_checker.sv */
`timescale 1ns / 1ps

module ddpt_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ddpt_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ddpt_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ddpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddpt_pkg::GAIN_BITS-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import ddpt_pkg::*;

  localparam int     LUT_DEPTH = 1024;
  localparam int     LUT_FRAC  = 14;
  localparam int     MU_SHIFT  = 22;
  localparam longint UNIT30    = longint'(1) <<< 30;
  localparam longint SYM_ONE   = 2048;

  int          sin_lut [LUT_DEPTH];
  int          cos_lut [LUT_DEPTH];

  logic [15:0] mu_gain;
  logic        qam16;
  logic [15:0] start_phase [2];
  logic [15:0] chan_phase  [2];
  out_item_t   expected_q [$];

  // odd polynomial for sin(pi/2 * t), t in Q30, Horner with truncating products
  function automatic longint quarter_wave(longint t);
    longint t2;
    longint p;
    longint s;
    longint r;
    t2 = t * t / UNIT30;
    p  = -3864;
    p  = 172272 + p * t2 / UNIT30;
    p  = -5026995 + p * t2 / UNIT30;
    p  = 85569306 + p * t2 / UNIT30;
    p  = -693598668 + p * t2 / UNIT30;
    p  = 1686629713 + p * t2 / UNIT30;
    s  = p * t / UNIT30;
    r  = (s + longint'(32768)) / longint'(65536);
    if (r < 0) r = 0;
    if (r > 16384) r = 16384;
    return r;
  endfunction

  function automatic longint quadrant_wave(int q, longint t);
    longint v;
    v = q[0] ? quarter_wave(UNIT30 - t) : quarter_wave(t);
    return q[1] ? -v : v;
  endfunction

  // floor(v / 2^sh + 1/2)
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // zero goes to +1; in 16-qam exactly +-2 goes outward
  function automatic longint decide(longint y);
    if (!qam16) return (y >= 0) ? SYM_ONE : -SYM_ONE;
    if (y >= 0) return (y >= 2 * SYM_ONE) ? 3 * SYM_ONE : SYM_ONE;
    return (y <= -2 * SYM_ONE) ? -3 * SYM_ONE : -SYM_ONE;
  endfunction

  function automatic out_item_t track_step(in_item_t it);
    longint    xr, xi, c, s, yr, yi, er, ei, g, delta;
    int        ch, idx;
    logic [15:0] ph;
    out_item_t res;
    xr = longint'($signed(it.sample_real));
    xi = longint'($signed(it.sample_imag));
    ch = int'(it.channel);
    if (it.restart) chan_phase[ch] = start_phase[ch];
    ph  = chan_phase[ch];
    idx = (int'(ph) * LUT_DEPTH) >>> 16;
    c   = cos_lut[idx];
    s   = sin_lut[idx];
    yr  = clip16(round_shift(xr * c + xi * s, LUT_FRAC));
    yi  = clip16(round_shift(xi * c - xr * s, LUT_FRAC));
    er  = yr - decide(yr);
    ei  = yi - decide(yi);
    g   = yi * er - yr * ei;
    delta = round_shift(longint'(mu_gain) * g, MU_SHIFT);
    ph  = 16'(longint'(ph) - delta);
    chan_phase[ch] = ph;
    res.rotated_real  = 16'(yr);
    res.rotated_imag  = 16'(yi);
    res.updated_phase = ph;
    res.channel_out   = it.channel;
    return res;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  initial begin
    for (int k = 0; k < LUT_DEPTH; k++) begin
      int     q;
      longint t;
      q = (4 * k) / LUT_DEPTH;
      t = longint'((4 * k) % LUT_DEPTH) * UNIT30 / LUT_DEPTH;
      sin_lut[k] = int'(quadrant_wave(q & 3, t));
      cos_lut[k] = int'(quadrant_wave((q + 1) & 3, t));
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mu_gain        = 16'd655;
      qam16          = 1'b0;
      start_phase[0] = '0;
      start_phase[1] = '0;
      chan_phase[0]  = '0;
      chan_phase[1]  = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_data.rotated_real !== want.rotated_real)
            report($sformatf("rotated_real got %0d want %0d",
                             $signed(out_data.rotated_real), $signed(want.rotated_real)));
          if (out_data.rotated_imag !== want.rotated_imag)
            report($sformatf("rotated_imag got %0d want %0d",
                             $signed(out_data.rotated_imag), $signed(want.rotated_imag)));
          if (out_data.updated_phase !== want.updated_phase)
            report($sformatf("updated_phase got %0d want %0d",
                             out_data.updated_phase, want.updated_phase));
          if (out_data.channel_out !== want.channel_out)
            report($sformatf("channel_out got %0d want %0d",
                             out_data.channel_out, want.channel_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP_SIZE:    mu_gain        = cfg_data;
          REG_CONST_MODE:   qam16          = cfg_data[0];
          REG_INIT_PHASE_A: start_phase[0] = cfg_data;
          REG_INIT_PHASE_B: start_phase[1] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(track_step(in_data));
    end
    pending <= expected_q.size();
  end

endmodule

/* tb/tb_decision_directed_phase_tracker.sv */
`timescale 1ns / 1ps

module tb_decision_directed_phase_tracker;
  import ddpt_pkg::*;

  // cycles with no handshake on any channel before the run is declared hung;
  // slowest legit stretch is a long input gap plus the work on one item plus
  // a long output stall
  localparam int IDLE_LIMIT   = 2000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_BITS-1:0] cfg_data = '0;

  int   error_cnt;
  int   pending_cnt;
  int   idle_cycles = 0;
  int   ready_gap;
  // when set, neither side inserts gaps
  logic steady = 1'b0;
  // slicer grid currently programmed, so random symbols land on it
  logic grid_qam = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  decision_directed_phase_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ddpt_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (error_cnt),
    .pending   (pending_cnt)
  );

  // gap lengths: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t sample_of(int re, int im, bit ch, bit rs);
    in_item_t it;
    it.sample_real = 16'(re);
    it.sample_imag = 16'(im);
    it.channel     = ch;
    it.restart     = rs;
    return it;
  endfunction

  // one axis of a random item, by flavor
  function automatic logic [15:0] axis_value(int kind, logic qam);
    int lv;
    if (kind < 60) begin
      // clean symbol on the programmed grid plus some noise
      lv = (qam && $urandom_range(0, 1)) ? 3 * 2048 : 2048;
      if ($urandom_range(0, 1)) lv = -lv;
      return 16'(lv + int'($urandom_range(0, 600)) - 300);
    end
    if (kind < 80) return 16'($urandom);
    if (kind < 90) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    // hover around the decision boundaries at 0 and +-2
    case ($urandom_range(0, 2))
      0:       lv = 0;
      1:       lv = 4096;
      default: lv = -4096;
    endcase
    return 16'(lv + int'($urandom_range(0, 4)) - 2);
  endfunction

  function automatic in_item_t make_item(logic qam);
    in_item_t it;
    int       kind;
    kind = $urandom_range(0, 99);
    it.sample_real = axis_value(kind, qam);
    it.sample_imag = axis_value(kind, qam);
    it.channel     = 1'($urandom_range(0, 1));
    it.restart     = ($urandom_range(0, 19) == 0);
    return it;
  endfunction

  // present one item and hold it until taken; valid stays up when no gap follows
  task automatic push_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // program the whole register set back to back, only while idle
  task automatic set_all(logic [15:0] mu, logic qam, logic [15:0] pa, logic [15:0] pb);
    set_reg(REG_STEP_SIZE, mu);
    set_reg(REG_CONST_MODE, {15'd0, qam});
    set_reg(REG_INIT_PHASE_A, pa);
    set_reg(REG_INIT_PHASE_B, pb);
    cfg_valid <= 1'b0;
    grid_qam = qam;
  endtask

  // wait until every item sent so far has come back
  task automatic drain();
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // result side: bursts of ready broken by random stalls
  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      ready_gap = pick_gap();
      if (ready_gap > 0) begin
        out_ready <= 1'b0;
        repeat (ready_gap) @(posedge clk);
      end
    end
  end

  // watchdog on forward progress of any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [15:0] mu;
    int          pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values; first item reads a phase nobody has written,
    // zero samples hit the slicer tie at zero
    push_item(sample_of(0, 0, 1'b0, 1'b0));
    push_item(sample_of(32767, -32768, 1'b1, 1'b0));
    push_item(sample_of(-32768, 32767, 1'b0, 1'b1));
    push_item(sample_of(2048, -2048, 1'b1, 1'b1));
    push_item(sample_of(-1, 1, 1'b0, 1'b0));
    in_valid <= 1'b0;
    drain();

    // full gain, 16-qam; channel a restarts at zero so +-2 ties show up
    // unrotated, channel b sits at 45 degrees to force saturation
    set_all(16'hffff, 1'b1, 16'h0000, 16'h2000);
    push_item(sample_of(4096, -4096, 1'b0, 1'b1));
    push_item(sample_of(0, 0, 1'b0, 1'b1));
    push_item(sample_of(6144, -6144, 1'b0, 1'b1));
    push_item(sample_of(-32768, -32768, 1'b1, 1'b1));
    push_item(sample_of(32767, 32767, 1'b1, 1'b1));
    push_item(sample_of(32767, -32768, 1'b1, 1'b1));
    push_item(sample_of(-32768, 32767, 1'b1, 1'b0));
    push_item(sample_of(1000, -3000, 1'b0, 1'b0));
    in_valid <= 1'b0;
    drain();

    // zero gain freezes the loop; top-of-range start phase
    set_all(16'h0000, 1'b0, 16'hffff, 16'h0000);
    push_item(sample_of(-32768, -32768, 1'b0, 1'b1));
    push_item(sample_of(2048, 2048, 1'b1, 1'b1));
    push_item(sample_of(-2048, -2048, 1'b0, 1'b0));
    push_item(sample_of(32767, 32767, 1'b1, 1'b0));
    in_valid <= 1'b0;
    drain();

    // smallest nonzero gain, half and three-quarter turn start phases
    set_all(16'h0001, 1'b1, 16'h8000, 16'hc000);
    push_item(sample_of(6000, -2000, 1'b0, 1'b1));
    push_item(sample_of(-6000, 2000, 1'b1, 1'b1));
    push_item(sample_of(-4096, 4096, 1'b1, 1'b0));
    push_item(sample_of(4095, -4097, 1'b0, 1'b0));
    in_valid <= 1'b0;
    drain();

    // random phases, each with its own register setting; the first one
    // runs without any gaps on either side
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      mu = 16'h0000;
      else if (pick == 1) mu = 16'hffff;
      else if (pick < 7)  mu = 16'($urandom_range(1, 4000));
      else                mu = 16'($urandom);
      set_all(mu, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      steady = (ph == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) push_item(make_item(grid_qam));
      in_valid <= 1'b0;
      drain();
      steady = 1'b0;
    end

    // settle a little past the block's latency before the verdict
    repeat (30) @(posedge clk);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ddpt_pkg.sv
rtl/core/ddpt_trig_rom.sv
rtl/core/decision_directed_phase_tracker.sv
tb/ddpt_checker.sv
tb/tb_decision_directed_phase_tracker.sv
